/* hw/rtl/xasf_pkg.sv */
// ----------------------------------------------------------------------------
// xasf_pkg
// Shared types and constants of the x86 ALU status flag unit.
// ----------------------------------------------------------------------------
package xasf_pkg;

  localparam int unsigned DataW = 64;

  typedef logic [DataW-1:0] data_t;

  // operand size codes
  typedef enum logic [1:0] {
    WidthB8  = 2'd0,
    WidthB16 = 2'd1,
    WidthB32 = 2'd2,
    WidthB64 = 2'd3
  } width_e;

  // operation codes; the unused codes above CmdOther behave like it
  typedef enum logic [3:0] {
    CmdAdd   = 4'd0,
    CmdInc   = 4'd1,
    CmdSub   = 4'd2,
    CmdCmp   = 4'd3,
    CmdDec   = 4'd4,
    CmdNeg   = 4'd5,
    CmdAnd   = 4'd6,
    CmdOr    = 4'd7,
    CmdXor   = 4'd8,
    CmdTest  = 4'd9,
    CmdShl   = 4'd10,
    CmdShr   = 4'd11,
    CmdSar   = 4'd12,
    CmdOther = 4'd13
  } cmd_e;

  // flag bit positions
  localparam int unsigned FlagCf = 0;
  localparam int unsigned FlagRs = 1;
  localparam int unsigned FlagPf = 2;
  localparam int unsigned FlagAf = 4;
  localparam int unsigned FlagZf = 6;
  localparam int unsigned FlagSf = 7;
  localparam int unsigned FlagOf = 11;

  localparam data_t ReservedMask = data_t'(1) << FlagRs;
  localparam data_t ArithMask    = (data_t'(1) << FlagCf) | (data_t'(1) << FlagPf) |
                                   (data_t'(1) << FlagAf) | (data_t'(1) << FlagZf) |
                                   (data_t'(1) << FlagSf) | (data_t'(1) << FlagOf);
  localparam data_t FlagsReset   = ReservedMask;

endpackage

/* hw/rtl/xasf_in_if.sv */
// ----------------------------------------------------------------------------
// xasf_in_if
// ALU event channel: operands, result, operand size and operation code.
// ----------------------------------------------------------------------------
interface xasf_in_if;
  import xasf_pkg::*;

  logic        valid;
  logic        ready;
  data_t       first_operand;
  data_t       second_operand;
  data_t       alu_result;
  logic [1:0]  width_code;
  logic [3:0]  command;

  modport source (
    output valid, first_operand, second_operand, alu_result, width_code, command,
    input  ready
  );

  modport sink (
    input  valid, first_operand, second_operand, alu_result, width_code, command,
    output ready
  );

endinterface

/* hw/rtl/xasf_out_if.sv */
// ----------------------------------------------------------------------------
// xasf_out_if
// Flags channel: the flags word after each ALU event.
// ----------------------------------------------------------------------------
interface xasf_out_if;
  import xasf_pkg::*;

  logic  valid;
  logic  ready;
  data_t flags_word;

  modport source (
    output valid, flags_word,
    input  ready
  );

  modport sink (
    input  valid, flags_word,
    output ready
  );

endinterface

/* hw/rtl/x86_alu_status_flags.sv */
// ----------------------------------------------------------------------------
// x86_alu_status_flags
// Recomputes CF, PF, AF, ZF, SF and OF of a kept flags register per ALU event.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake     payload
//  -------  ---  ------------  ----------------------------------------------
//  in_i     in   valid/ready   first_operand, second_operand, alu_result,
//                              width_code, command
//  out_o    out  valid/ready   flags_word
//
// One event per cycle while out_o does not stall. An event is held in the input
// register, then its flags word is computed and loaded into the flags register,
// which is also the output register.
// Reset sets the flags word to 0x2 and empties both stages.
// When out_o stalls, the input register still takes one more event.
// ----------------------------------------------------------------------------
module x86_alu_status_flags (
  input  logic clk_i,
  input  logic rst_ni,
  xasf_in_if.sink    in_i,
  xasf_out_if.source out_o
);
  import xasf_pkg::*;

  // input register
  logic       s1_valid_q, s1_valid_d;
  data_t      s1_a_q, s1_b_q, s1_r_q;
  logic [1:0] s1_width_q;
  logic [3:0] s1_cmd_q;

  // flags register doubles as output register
  logic  out_valid_q, out_valid_d;
  data_t flags_q, flags_d;

  logic advance;
  logic in_xfer;

  assign advance = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_xfer = in_i.valid && in_i.ready;

  assign out_o.valid = out_valid_q;
  assign out_o.flags_word = flags_q;

  // flag computation
  data_t       mask;
  logic [6:0]  size;
  logic [5:0]  top;
  data_t       a, b, r;
  logic        sa, sb, sr;
  logic [64:0] sum;
  logic [4:0]  nib_sum;
  logic        cnt_small;
  logic [6:0]  cnt;
  logic        cnt_in_range;
  logic [5:0]  shl_idx, shr_idx;
  logic        cf, af, of;

  always_comb begin
    unique case (width_e'(s1_width_q))
      WidthB8:  mask = data_t'(8'hFF);
      WidthB16: mask = data_t'(16'hFFFF);
      WidthB32: mask = data_t'(32'hFFFF_FFFF);
      WidthB64: mask = '1;
      default:  mask = '1;
    endcase
    size = 7'd8 << s1_width_q;
    top  = 6'(size - 7'd1);
    a  = s1_a_q & mask;
    b  = s1_b_q & mask;
    r  = s1_r_q & mask;
    sa = a[top];
    sb = b[top];
    sr = r[top];

    sum     = {1'b0, a} + {1'b0, b};
    nib_sum = {1'b0, a[3:0]} + {1'b0, b[3:0]};

    // shift count is only meaningful up to the operand size
    cnt_small    = (b[63:7] == '0);
    cnt          = b[6:0];
    cnt_in_range = cnt_small && (cnt != 7'd0) && (cnt <= size);
    shl_idx      = 6'(size - cnt);
    shr_idx      = 6'(cnt - 7'd1);

    cf = 1'b0;
    af = 1'b0;
    of = 1'b0;
    unique case (cmd_e'(s1_cmd_q))
      CmdAdd, CmdInc: begin
        cf = sum[size];
        af = nib_sum[4];
        of = (sa == sb) && (sa != sr);
      end
      CmdSub, CmdCmp, CmdDec: begin
        cf = a < b;
        af = a[3:0] < b[3:0];
        of = (sa != sb) && (sa != sr);
      end
      CmdNeg: begin
        cf = (r != '0);
        af = a[3:0] < b[3:0];
        of = (a == (data_t'(1) << top));
      end
      CmdAnd, CmdOr, CmdXor, CmdTest: begin
        cf = 1'b0;
      end
      CmdShl: begin
        cf = cnt_in_range && a[shl_idx];
        of = (b == data_t'(1)) && (sa != sr);
      end
      CmdShr: begin
        cf = cnt_in_range && a[shr_idx];
        of = (b == data_t'(1)) && sa;
      end
      CmdSar: begin
        // count beyond the size fills CF with the sign
        if (cnt_in_range) begin
          cf = a[shr_idx];
        end else if (b != '0) begin
          cf = sa;
        end
      end
      default: begin
        cf = flags_q[FlagCf];
      end
    endcase

    flags_d = (flags_q & ~ArithMask) | ReservedMask;
    flags_d[FlagCf] = cf;
    flags_d[FlagPf] = ~^r[7:0];
    flags_d[FlagAf] = af;
    flags_d[FlagZf] = (r == '0);
    flags_d[FlagSf] = sr;
    flags_d[FlagOf] = of;
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= FlagsReset;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        flags_q <= flags_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_a_q     <= in_i.first_operand;
      s1_b_q     <= in_i.second_operand;
      s1_r_q     <= in_i.alu_result;
      s1_width_q <= in_i.width_code;
      s1_cmd_q   <= in_i.command;
    end
  end

`ifndef SYNTH
  // only the arithmetic flags and the reserved bit ever become set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flags_q & ~(ArithMask | ReservedMask)) == '0 && flags_q[FlagRs])
    else $error("flags word has bits outside the flag set");

  // input side stalls only with both stages full and the output blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> s1_valid_q && out_valid_q && !out_o.ready)
    else $error("input stalled without backpressure");

  // a held event is not dropped while the output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_o.ready |=> s1_valid_q && out_valid_q)
    else $error("event lost during output stall");

  // flags change only when an event moves to the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(flags_q))
    else $error("flags changed without an event");
`endif

endmodule

/* bench/tb_x86_alu_status_flags.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_x86_alu_status_flags
// Drives ALU events into the status flag unit and checks every flags word
// against a pinned table value or a cycle-free predictor that tracks its own
// copy of the flags register. A short table of hand-picked events comes first,
// then random events under three idle patterns and one long output stall.
// ----------------------------------------------------------------------------
module tb_x86_alu_status_flags;
  import xasf_pkg::*;

  localparam int unsigned HoldOffCycles = 64;
  localparam int unsigned RandomPerPhase = 200;

  typedef struct {
    data_t      first_operand;
    data_t      second_operand;
    data_t      alu_result;
    width_e     width_code;
    logic [3:0] command;
  } alu_event_t;

  typedef struct {
    alu_event_t ev;
    bit         pinned;
    data_t      flags;
  } table_row_t;

  logic clk;
  logic rst_n;

  xasf_in_if  in_ch ();
  xasf_out_if out_ch ();

  x86_alu_status_flags u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  data_t        flags_state;
  data_t        flags_due[$];
  table_row_t   directed_rows[$];
  int unsigned  src_idle_pct;
  int unsigned  snk_idle_pct;
  bit           hold_off_req;
  int unsigned  mismatches;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Expected flags word after one event, given the flags word before it.
  function automatic data_t recompute_flags(input data_t prev, input alu_event_t ev);
    int unsigned size;
    data_t mask;
    data_t a;
    data_t b;
    data_t r;
    data_t f;
    logic sa;
    logic sb;
    logic sr;
    logic cf;
    logic af;
    logic of;
    size = 8 << ev.width_code;
    mask = (size == DataW) ? '1 : ((data_t'(1) << size) - 1);
    a = ev.first_operand & mask;
    b = ev.second_operand & mask;
    r = ev.alu_result & mask;
    sa = a[size-1];
    sb = b[size-1];
    sr = r[size-1];
    cf = 1'b0;
    af = 1'b0;
    of = 1'b0;
    case (ev.command)
      CmdAdd, CmdInc: begin
        cf = ((a + b) & mask) < a;
        af = ({1'b0, a[3:0]} + {1'b0, b[3:0]}) > 5'd15;
        of = (sa == sb) && (sa != sr);
      end
      CmdSub, CmdCmp, CmdDec: begin
        cf = a < b;
        af = a[3:0] < b[3:0];
        of = (sa != sb) && (sa != sr);
      end
      CmdNeg: begin
        cf = (r != 0);
        af = a[3:0] < b[3:0];
        of = (a == (data_t'(1) << (size - 1)));
      end
      CmdAnd, CmdOr, CmdXor, CmdTest: begin
      end
      CmdShl: begin
        if (b != 0 && b <= size) cf = a[size - b];
        of = (b == 1) && (sa != sr);
      end
      CmdShr: begin
        if (b != 0 && b <= size) cf = a[b - 1];
        of = (b == 1) && sa;
      end
      CmdSar: begin
        // counts past the size shift in copies of the sign
        if (b != 0) cf = (b <= size) ? a[b - 1] : sa;
      end
      default: cf = prev[FlagCf];
    endcase
    f = (prev & ~ArithMask) | ReservedMask;
    f[FlagCf] = cf;
    f[FlagPf] = ~^r[7:0];
    f[FlagAf] = af;
    f[FlagZf] = (r == 0);
    f[FlagSf] = sr;
    f[FlagOf] = of;
    return f;
  endfunction

  function automatic data_t pick_operand(input int unsigned size);
    data_t msb;
    msb = data_t'(1) << (size - 1);
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return msb;
      3: return msb - 1;
      4: return data_t'($urandom_range(15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic alu_event_t random_event();
    alu_event_t ev;
    int unsigned size;
    data_t mask;
    data_t a;
    data_t b;
    ev.width_code = width_e'($urandom_range(3));
    size = 8 << ev.width_code;
    mask = (size == DataW) ? '1 : ((data_t'(1) << size) - 1);
    ev.command = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 13)) : 4'($urandom_range(12));
    a = pick_operand(size);
    b = pick_operand(size);
    case (ev.command)
      CmdInc, CmdDec: b = 1;
      CmdShl, CmdShr, CmdSar: begin
        // mostly counts around the size, garbage above it
        if ($urandom_range(4) != 0)
          b = data_t'($urandom_range(size + 1)) | ({$urandom, $urandom} & ~mask);
      end
      default: ;
    endcase
    ev.first_operand = a;
    ev.second_operand = b;
    case (ev.command)
      CmdAdd, CmdInc:         ev.alu_result = a + b;
      CmdSub, CmdCmp, CmdDec: ev.alu_result = a - b;
      CmdNeg:                 ev.alu_result = -a;
      CmdAnd, CmdTest:        ev.alu_result = a & b;
      CmdOr:                  ev.alu_result = a | b;
      CmdXor:                 ev.alu_result = a ^ b;
      CmdShl:                 ev.alu_result = a << (b & mask);
      CmdShr, CmdSar:         ev.alu_result = (a & mask) >> (b & mask);
      default:                ev.alu_result = {$urandom, $urandom};
    endcase
    if ($urandom_range(3) == 0) ev.alu_result = {$urandom, $urandom};
    return ev;
  endfunction

  task automatic add_row(input data_t a, input data_t b, input data_t r, input width_e w,
                         input logic [3:0] c, input bit pinned, input data_t flags);
    table_row_t row;
    row.ev.first_operand = a;
    row.ev.second_operand = b;
    row.ev.alu_result = r;
    row.ev.width_code = w;
    row.ev.command = c;
    row.pinned = pinned;
    row.flags = flags;
    directed_rows.push_back(row);
  endtask

  // Offer one event from a falling edge; return at the falling edge after its transfer.
  task automatic send_event(input alu_event_t ev, input bit pinned, input data_t pinned_flags);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.first_operand = ev.first_operand;
    in_ch.second_operand = ev.second_operand;
    in_ch.alu_result = ev.alu_result;
    in_ch.width_code = ev.width_code;
    in_ch.command = ev.command;
    do @(posedge clk); while (!in_ch.ready);
    flags_state = recompute_flags(flags_state, ev);
    flags_due.push_back(pinned ? pinned_flags : flags_state);
    @(negedge clk);
  endtask

  // Result side: random ready, or one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready = 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk);
      end else begin
        out_ch.ready = ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (flags_due.size() == 0) begin
        $error("flags_word transfer with nothing outstanding: %h", out_ch.flags_word);
        mismatches++;
      end else begin
        if (out_ch.flags_word !== flags_due[0]) begin
          $error("flags_word mismatch: expected %h, actual %h", flags_due[0],
                 out_ch.flags_word);
          mismatches++;
        end
        void'(flags_due.pop_front());
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb_x86_alu_status_flags: FAIL");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.first_operand = '0;
    in_ch.second_operand = '0;
    in_ch.alu_result = '0;
    in_ch.width_code = WidthB8;
    in_ch.command = CmdAdd;
    flags_state = FlagsReset;
    src_idle_pct = 36;
    snk_idle_pct = 49;
    hold_off_req = 1'b0;
    mismatches = 0;

    // zero result from reset, carries out of 8 and 64 bits, signed overflow, a borrow
    add_row(64'h0, 64'h0, 64'h0, WidthB8, CmdAdd, 1'b1, 64'h46);
    add_row(64'hFF, 64'h01, 64'h00, WidthB8, CmdAdd, 1'b1, 64'h57);
    add_row('1, 64'h1, 64'h0, WidthB64, CmdAdd, 1'b1, 64'h57);
    add_row(64'h7F, 64'h01, 64'h80, WidthB8, CmdAdd, 1'b1, 64'h892);
    add_row(64'h0, 64'h1, 64'hFFFF_FFFF, WidthB32, CmdSub, 1'b1, 64'h97);
    // unlisted operations keep the carry just set
    add_row(64'h0, 64'h0, 64'h01, WidthB8, CmdOther, 1'b1, 64'h03);
    add_row(64'h5, 64'h9, 64'h1234, WidthB16, 4'd14, 1'b0, '0);
    add_row('1, '1, 64'h0, WidthB64, 4'd15, 1'b0, '0);
    add_row(64'hFFFF, 64'h1, 64'h0, WidthB16, CmdInc, 1'b0, '0);
    add_row(64'h8000_0000_0000_0000, 64'h1, 64'h7FFF_FFFF_FFFF_FFFF, WidthB64, CmdCmp,
            1'b0, '0);
    add_row(64'h80, 64'h1, 64'h7F, WidthB8, CmdDec, 1'b0, '0);
    add_row(64'h8000, 64'h8000, 64'h8000, WidthB16, CmdNeg, 1'b0, '0);
    add_row(64'h0, 64'h0, 64'h0, WidthB32, CmdNeg, 1'b0, '0);
    // upper garbage must be cut off
    add_row(64'hFFFF_FFFF_0000_0000, '1, 64'hDEAD_BEEF_0000_0000, WidthB32, CmdAnd,
            1'b0, '0);
    add_row(64'h0F, 64'hF0, 64'hFF, WidthB8, CmdOr, 1'b0, '0);
    add_row(64'hAA, 64'hAA, 64'h00, WidthB8, CmdXor, 1'b0, '0);
    add_row('1, 64'h8000_0000, 64'h8000_0000, WidthB32, CmdTest, 1'b0, '0);
    // shift counts: zero, one, equal to the size, just past it
    add_row(64'h81, 64'h0, 64'h81, WidthB8, CmdShl, 1'b0, '0);
    add_row(64'h81, 64'h1, 64'h02, WidthB8, CmdShl, 1'b0, '0);
    add_row(64'h01, 64'h8, 64'h00, WidthB8, CmdShl, 1'b0, '0);
    add_row(64'h81, 64'h9, 64'h00, WidthB8, CmdShl, 1'b0, '0);
    add_row('1, 64'd64, 64'h0, WidthB64, CmdShr, 1'b0, '0);
    add_row(64'h8001, 64'h1, 64'h4000, WidthB16, CmdShr, 1'b0, '0);
    add_row(64'h80, 64'd200, 64'hFF, WidthB8, CmdSar, 1'b0, '0);
    add_row(64'h8000_0001, 64'h0, 64'h8000_0001, WidthB32, CmdSar, 1'b0, '0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_event(directed_rows[i].ev, directed_rows[i].pinned, directed_rows[i].flags);
    repeat (RandomPerPhase) send_event(random_event(), 1'b0, '0);

    src_idle_pct = 49;
    snk_idle_pct = 36;
    repeat (RandomPerPhase) send_event(random_event(), 1'b0, '0);

    // back-to-back; stall the output long enough to fill the pipe
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_off_req = 1'b1;
    repeat (RandomPerPhase) send_event(random_event(), 1'b0, '0);
    in_ch.valid = 1'b0;

    while (flags_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_x86_alu_status_flags: PASS");
    end else begin
      $display("tb_x86_alu_status_flags: FAIL");
    end
    $finish;
  end

endmodule
